>>> rtl/epoch_seconds_to_calendar_macros.svh
// Assertion helpers used by the checker file es2c_chk.sv.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ES2C_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ES2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/es2c_pkg.sv
`timescale 1ns / 1ps
package es2c_pkg;

  typedef logic [8:0] yday_t;
  typedef logic [3:0] mon_t;

  localparam logic [31:0] LIMIT_SECS   = 32'd4102444800;
  localparam logic [16:0] DAY_SECS     = 17'd86400;
  localparam logic [11:0] HOUR_SECS    = 12'd3600;
  localparam logic [5:0]  MIN_SECS     = 6'd60;
  localparam logic [10:0] CYC_DAYS     = 11'd1461;
  localparam logic [10:0] Y1_END       = 11'd365;
  localparam logic [10:0] Y2_END       = 11'd730;
  localparam logic [10:0] Y3_END       = 11'd1096;
  localparam logic [7:0]  BASE_YEAR    = 8'd70;
  localparam logic [2:0]  BASE_WEEKDAY = 3'd4;

  // reciprocals: x / 675 (x < 2^25) = (x * DAY_RECIP) >> 35
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  // d / 1461 (d < 2^16) = (d * CYC_RECIP) >> 27
  localparam logic [16:0] CYC_RECIP  = 17'd91868;
  // x / 225 (x < 2^13) = (x * HOUR_RECIP) >> 21
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  // x / 60 (x < 2^12) = (x * MIN_RECIP) >> 17
  localparam logic [11:0] MIN_RECIP  = 12'd2185;

  localparam yday_t CUM_LEAP [13] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
  };
  localparam yday_t CUM_COMMON [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

endpackage

>>> rtl/es2c_month.sv
`timescale 1ns / 1ps
module es2c_month
  import es2c_pkg::*;
(
  input  yday_t      yday,
  input  logic       leap,
  output mon_t       mon,
  output logic [4:0] mday
);

  yday_t base;
  yday_t diff;

  always_comb begin
    mon = '0;
    for (int i = 1; i < 12; i++) begin
      if ((leap ? CUM_LEAP[i] : CUM_COMMON[i]) <= yday) begin
        mon = mon + 4'd1;
      end
    end
  end

  assign base = leap ? CUM_LEAP[mon] : CUM_COMMON[mon];
  assign diff = yday - base + 9'd1;
  assign mday = diff[4:0];

endmodule

>>> rtl/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into
// broken-down UTC date and time fields.
// Input channel: in_valid / in_stall with in_epoch_seconds; a beat moves on
// a rising edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall with one port per field; exactly one
// result beat per input beat, in order.
// Throughput: one beat per cycle while out_stall is low, held by a
// seven-register pipeline (input register, five working stages, output
// register) in which each stage holds at most one constant-reciprocal
// multiply.
// Stall: a stage loads when it is empty or the stage after it moves, so
// bubbles close up and up to seven beats sit in flight; in_stall rises only
// when every stage is full and out_stall is high. A stalled result holds.
// Inputs at or past 2100-01-01 00:00:00 give out_out_of_range = 1 with all
// other fields zero.
// Reset (rst_n low, synchronous) empties every stage; no result is lost or
// invented afterward.
module epoch_seconds_to_calendar
  import es2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_year_since_1900,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour_of_day,
  output logic [5:0]  out_minute_of_hour,
  output logic [5:0]  out_second_of_minute,
  output logic [2:0]  out_weekday,
  output logic [8:0]  out_day_of_year,
  output logic        out_out_of_range
);

  logic [6:0] vld_r;
  logic [6:0] ld;

  logic [31:0] s1_secs_r;
  logic [50:0] s1_prod;
  logic [15:0] days_nxt;

  logic [15:0] s2_days_r;
  logic [16:0] s2_lo_r;
  logic        s2_oor_r;
  logic [32:0] s2_dsec;
  logic [32:0] s2_cprod;
  logic [16:0] sod_nxt;
  logic [5:0]  cyc_nxt;
  logic [5:0]  oct_sum;
  logic [3:0]  oct_fold;
  logic [2:0]  wday_nxt;

  logic [15:0] s3_days_r;
  logic [5:0]  s3_cyc_r;
  logic [16:0] s3_sod_r;
  logic [2:0]  s3_wday_r;
  logic        s3_oor_r;
  logic [16:0] s3_cdays;
  logic [15:0] dic_diff;
  logic [26:0] s3_hprod;
  logic [4:0]  hour_nxt;

  logic [10:0] s4_dic_r;
  logic [5:0]  s4_cyc_r;
  logic [16:0] s4_sod_r;
  logic [4:0]  s4_hour_r;
  logic [2:0]  s4_wday_r;
  logic        s4_oor_r;
  logic [10:0] yday_full;
  logic [1:0]  yic;
  logic        leap_nxt;
  logic [7:0]  year_nxt;
  logic [16:0] s4_hsec;
  logic [16:0] soh_diff;

  logic [7:0]  s5_year_r;
  yday_t       s5_yday_r;
  logic        s5_leap_r;
  logic [11:0] s5_soh_r;
  logic [4:0]  s5_hour_r;
  logic [2:0]  s5_wday_r;
  logic        s5_oor_r;
  mon_t        mon_nxt;
  logic [4:0]  mday_nxt;
  logic [23:0] s5_mprod;

  logic [7:0]  s6_year_r;
  mon_t        s6_mon_r;
  logic [4:0]  s6_mday_r;
  yday_t       s6_yday_r;
  logic [4:0]  s6_hour_r;
  logic [5:0]  s6_min_r;
  logic [11:0] s6_soh_r;
  logic [2:0]  s6_wday_r;
  logic        s6_oor_r;
  logic [11:0] s6_msec;
  logic [11:0] sec_diff;

  // advance chain, output side first
  always_comb begin
    ld[6] = !vld_r[6] || !out_stall;
    for (int k = 5; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = vld_r[6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < 7; k++) begin
        if (ld[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign s1_prod  = s1_secs_r[31:7] * DAY_RECIP;
  assign days_nxt = s1_prod[50:35];

  assign s2_dsec  = s2_days_r * DAY_SECS;
  assign sod_nxt  = s2_lo_r - s2_dsec[16:0];
  assign s2_cprod = s2_days_r * CYC_RECIP;
  assign cyc_nxt  = s2_cprod[32:27];

  // octal digits sum to the value mod 7
  assign oct_sum = 6'(s2_days_r[2:0]) + 6'(s2_days_r[5:3]) + 6'(s2_days_r[8:6])
                 + 6'(s2_days_r[11:9]) + 6'(s2_days_r[14:12]) + 6'(s2_days_r[15])
                 + 6'(BASE_WEEKDAY);
  assign oct_fold = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
  assign wday_nxt = (oct_fold >= 4'd7) ? 3'(oct_fold - 4'd7) : oct_fold[2:0];

  assign s3_cdays = s3_cyc_r * CYC_DAYS;
  assign dic_diff = s3_days_r - s3_cdays[15:0];
  assign s3_hprod = s3_sod_r[16:4] * HOUR_RECIP;
  assign hour_nxt = s3_hprod[25:21];

  always_comb begin
    priority if (s4_dic_r < Y1_END) begin
      yic       = 2'd0;
      yday_full = s4_dic_r;
      leap_nxt  = 1'b0;
    end else if (s4_dic_r < Y2_END) begin
      yic       = 2'd1;
      yday_full = s4_dic_r - Y1_END;
      leap_nxt  = 1'b0;
    end else if (s4_dic_r < Y3_END) begin
      yic       = 2'd2;
      yday_full = s4_dic_r - Y2_END;
      leap_nxt  = 1'b1;
    end else begin
      yic       = 2'd3;
      yday_full = s4_dic_r - Y3_END;
      leap_nxt  = 1'b0;
    end
  end

  assign year_nxt = BASE_YEAR + {s4_cyc_r, 2'b00} + 8'(yic);
  assign s4_hsec  = s4_hour_r * HOUR_SECS;
  assign soh_diff = s4_sod_r - s4_hsec;

  es2c_month u_month (
    .yday (s5_yday_r),
    .leap (s5_leap_r),
    .mon  (mon_nxt),
    .mday (mday_nxt)
  );

  assign s5_mprod = s5_soh_r * MIN_RECIP;

  assign s6_msec  = s6_min_r * MIN_SECS;
  assign sec_diff = s6_soh_r - s6_msec;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_secs_r <= in_epoch_seconds;
    end
    if (ld[1]) begin
      s2_days_r <= days_nxt;
      s2_lo_r   <= s1_secs_r[16:0];
      s2_oor_r  <= (s1_secs_r >= LIMIT_SECS);
    end
    if (ld[2]) begin
      s3_days_r <= s2_days_r;
      s3_cyc_r  <= cyc_nxt;
      s3_sod_r  <= sod_nxt;
      s3_wday_r <= wday_nxt;
      s3_oor_r  <= s2_oor_r;
    end
    if (ld[3]) begin
      s4_dic_r  <= dic_diff[10:0];
      s4_cyc_r  <= s3_cyc_r;
      s4_sod_r  <= s3_sod_r;
      s4_hour_r <= hour_nxt;
      s4_wday_r <= s3_wday_r;
      s4_oor_r  <= s3_oor_r;
    end
    if (ld[4]) begin
      s5_year_r <= year_nxt;
      s5_yday_r <= yday_full[8:0];
      s5_leap_r <= leap_nxt;
      s5_soh_r  <= soh_diff[11:0];
      s5_hour_r <= s4_hour_r;
      s5_wday_r <= s4_wday_r;
      s5_oor_r  <= s4_oor_r;
    end
    if (ld[5]) begin
      s6_year_r <= s5_year_r;
      s6_mon_r  <= mon_nxt;
      s6_mday_r <= mday_nxt;
      s6_yday_r <= s5_yday_r;
      s6_hour_r <= s5_hour_r;
      s6_min_r  <= s5_mprod[22:17];
      s6_soh_r  <= s5_soh_r;
      s6_wday_r <= s5_wday_r;
      s6_oor_r  <= s5_oor_r;
    end
    if (ld[6]) begin
      out_out_of_range <= s6_oor_r;
      if (s6_oor_r) begin
        out_year_since_1900  <= '0;
        out_month_index      <= '0;
        out_day_of_month     <= '0;
        out_hour_of_day      <= '0;
        out_minute_of_hour   <= '0;
        out_second_of_minute <= '0;
        out_weekday          <= '0;
        out_day_of_year      <= '0;
      end else begin
        out_year_since_1900  <= s6_year_r;
        out_month_index      <= s6_mon_r;
        out_day_of_month     <= s6_mday_r;
        out_hour_of_day      <= s6_hour_r;
        out_minute_of_hour   <= s6_min_r;
        out_second_of_minute <= sec_diff[5:0];
        out_weekday          <= s6_wday_r;
        out_day_of_year      <= s6_yday_r;
      end
    end
  end

endmodule

>>> rtl/es2c_chk.sv
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_macros.svh"
module es2c_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_year_since_1900,
  input logic [3:0]  out_month_index,
  input logic [4:0]  out_day_of_month,
  input logic [4:0]  out_hour_of_day,
  input logic [5:0]  out_minute_of_hour,
  input logic [5:0]  out_second_of_minute,
  input logic [2:0]  out_weekday,
  input logic [8:0]  out_day_of_year,
  input logic        out_out_of_range
);

  logic fields_ok;
  logic rest_zero;
  logic [46:0] out_bits;

  assign fields_ok = (out_year_since_1900 >= 8'd70) && (out_year_since_1900 <= 8'd199)
                  && (out_month_index <= 4'd11) && (out_day_of_month >= 5'd1)
                  && (out_hour_of_day <= 5'd23) && (out_minute_of_hour <= 6'd59)
                  && (out_second_of_minute <= 6'd59) && (out_weekday <= 3'd6)
                  && (out_day_of_year <= 9'd365);

  assign rest_zero = (out_year_since_1900 == '0) && (out_month_index == '0)
                  && (out_day_of_month == '0) && (out_hour_of_day == '0)
                  && (out_minute_of_hour == '0) && (out_second_of_minute == '0)
                  && (out_weekday == '0) && (out_day_of_year == '0);

  assign out_bits = {out_year_since_1900, out_month_index, out_day_of_month,
                     out_hour_of_day, out_minute_of_hour, out_second_of_minute,
                     out_weekday, out_day_of_year, out_out_of_range};

  `ES2C_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")
  `ES2C_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_bits), "stalled beat changed")
  `ES2C_ASSERT_NOW(a_fields, out_valid && !out_out_of_range, fields_ok, "field out of range")
  `ES2C_ASSERT_NOW(a_oor_zero, out_valid && out_out_of_range, rest_zero, "out of range beat not zeroed")
  `ES2C_ASSERT_NOW(a_reset_empty, !$past(rst_n), !out_valid, "result valid right after reset")

endmodule

bind epoch_seconds_to_calendar es2c_chk u_es2c_chk (.*);

>>> sim/tb_epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
module tb_epoch_seconds_to_calendar
  import es2c_pkg::*;
();

  localparam int unsigned        CYCLE_LIMIT = 200000;
  localparam int unsigned        LONG_HOLD   = 200;
  localparam int unsigned        DRAIN       = 16;
  localparam int unsigned        DAY_LEN     = 86400;
  localparam int unsigned        LAST_DAY    = 47481;
  localparam logic [31:0]        EPOCH_2100  = 32'd4102444800;
  localparam int unsigned        MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [31:0] secs;
    logic [7:0]  year;
    mon_t        month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
    logic [2:0]  wday;
    yday_t       yday;
    logic        past_2099;
  } calendar_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_year_since_1900;
  logic [3:0]  out_month_index;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour_of_day;
  logic [5:0]  out_minute_of_hour;
  logic [5:0]  out_second_of_minute;
  logic [2:0]  out_weekday;
  logic [8:0]  out_day_of_year;
  logic        out_out_of_range;

  calendar_t   cal_expected [$];
  bit          idle_on = 1'b1;
  int unsigned hold_req_seq = 0;
  int unsigned beats_sent = 0;
  int unsigned past_2099_beats = 0;
  int unsigned results_checked = 0;
  int unsigned stalled_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  epoch_seconds_to_calendar u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_year_since_1900  (out_year_since_1900),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute),
    .out_weekday          (out_weekday),
    .out_day_of_year      (out_day_of_year),
    .out_out_of_range     (out_out_of_range)
  );

  always #5 clk = ~clk;

  function automatic calendar_t calendar_of(input logic [31:0] secs);
    calendar_t   c;
    int unsigned days;
    int unsigned sod;
    int unsigned year;
    int unsigned mon;
    int unsigned mlen;
    bit          leap;
    c = '{default: '0};
    c.secs = secs;
    if (secs >= EPOCH_2100) begin
      c.past_2099 = 1'b1;
      return c;
    end
    days = secs / DAY_LEN;
    sod = secs % DAY_LEN;
    c.wday = 3'((days + 4) % 7);
    year = 70;
    while (days >= ((year % 4 == 0) ? 366 : 365)) begin
      days -= (year % 4 == 0) ? 366 : 365;
      year++;
    end
    leap = (year % 4 == 0);
    c.year = 8'(year);
    c.yday = 9'(days);
    mon = 0;
    mlen = MONTH_LEN[0];
    while (days >= mlen) begin
      days -= mlen;
      mon++;
      mlen = MONTH_LEN[mon] + ((mon == 1 && leap) ? 1 : 0);
    end
    c.month = 4'(mon);
    c.mday = 5'(days + 1);
    c.hour = 5'(sod / 3600);
    c.minute = 6'((sod % 3600) / 60);
    c.sec = 6'(sod % 60);
    return c;
  endfunction

  function automatic logic [31:0] random_secs();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, LAST_DAY) * DAY_LEN + ($urandom_range(0, 1) ? DAY_LEN - 1 : 0);
      2: return $urandom_range(EPOCH_2100 - 200000, 32'hFFFF_FFFF);
      3: return ($urandom_range(0, 31) * 1461 + 730 + $urandom_range(58, 60)) * DAY_LEN
                + $urandom_range(0, DAY_LEN - 1);
      default: return $urandom_range(0, EPOCH_2100 - 1);
    endcase
  endfunction

  task automatic send_beat(input logic [31:0] secs);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cal_expected.push_back(calendar_of(secs));
    beats_sent++;
    if (secs >= EPOCH_2100) past_2099_beats++;
  endtask

  task automatic check_field(input logic [31:0] secs, input string field,
                             input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: secs %0d %s expected %0d actual %0d", $time, secs, field, want, got);
      mismatches++;
    end
  endtask

  task automatic test_directed();
    logic [31:0] points [$];
    idle_on <= 1'b1;
    points = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
               32'd2678399, 32'd2678400, 32'd5097600, 32'd31535999, 32'd31536000,
               32'd68169600, 32'd94607999, 32'd94694400, 32'd951782400,
               32'd2147483647, 32'd2147483648, 32'hAAAA_AAAA, 32'h5555_5555,
               32'd3981312000, 32'd4102444799, 32'd4102444800, 32'hFFFF_FFFF};
    foreach (points[i]) send_beat(points[i]);
  endtask

  task automatic test_random();
    idle_on <= 1'b1;
    repeat (750) send_beat(random_secs());
  endtask

  task automatic test_back_to_back();
    idle_on <= 1'b0;
    repeat (150) send_beat(random_secs());
  endtask

  task automatic test_backpressure();
    idle_on <= 1'b0;
    hold_req_seq <= hold_req_seq + 1;
    repeat (60) send_beat(random_secs());
  endtask

  // receiver: random wait per result when idle_on is set, plus a long hold on request
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  always @(posedge clk) begin
    if (hold_seen != hold_req_seq) begin
      hold_seen = hold_req_seq;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) rx_wait = idle_on ? $urandom_range(0, 7) : 0;
      if (rx_wait != 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    calendar_t want;
    if (rst_n && in_valid && in_stall) stalled_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (cal_expected.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual year %0d", $time,
                 out_year_since_1900);
        mismatches++;
      end else begin
        want = cal_expected.pop_front();
        check_field(want.secs, "year_since_1900", want.year, out_year_since_1900);
        check_field(want.secs, "month_index", want.month, out_month_index);
        check_field(want.secs, "day_of_month", want.mday, out_day_of_month);
        check_field(want.secs, "hour_of_day", want.hour, out_hour_of_day);
        check_field(want.secs, "minute_of_hour", want.minute, out_minute_of_hour);
        check_field(want.secs, "second_of_minute", want.sec, out_second_of_minute);
        check_field(want.secs, "weekday", want.wday, out_weekday);
        check_field(want.secs, "day_of_year", want.yday, out_day_of_year);
        check_field(want.secs, "out_of_range", want.past_2099, out_out_of_range);
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               cal_expected.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_back_to_back();
    test_backpressure();
    in_valid <= 1'b0;
    while (cal_expected.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("%0d timestamps converted and %0d results compared, %0d past year 2099",
             beats_sent, results_checked, past_2099_beats);
    $display("input held off on %0d cycles by a full pipeline; %0d mismatches",
             stalled_cycles, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
